FILE: rtl/core/vwia_pkg.sv
`timescale 1ns / 1ps

package vwia_pkg;

	localparam int WORD = 64;
	localparam int DATA_WIDTH_DEF = 64;

	localparam logic [4:0] FN_ADD   = 5'd0;
	localparam logic [4:0] FN_SUB   = 5'd1;
	localparam logic [4:0] FN_MUL   = 5'd2;
	localparam logic [4:0] FN_SDIV  = 5'd3;
	localparam logic [4:0] FN_UDIV  = 5'd4;
	localparam logic [4:0] FN_SREM  = 5'd5;
	localparam logic [4:0] FN_UREM  = 5'd6;
	localparam logic [4:0] FN_AND   = 5'd7;
	localparam logic [4:0] FN_OR    = 5'd8;
	localparam logic [4:0] FN_XOR   = 5'd9;
	localparam logic [4:0] FN_SHL   = 5'd10;
	localparam logic [4:0] FN_LSHR  = 5'd11;
	localparam logic [4:0] FN_ASHR  = 5'd12;
	localparam logic [4:0] FN_ICMP  = 5'd13;
	localparam logic [4:0] FN_TRUNC = 5'd14;
	localparam logic [4:0] FN_ZEXT  = 5'd15;
	localparam logic [4:0] FN_SEXT  = 5'd16;

	localparam logic [3:0] PR_EQ  = 4'd0;
	localparam logic [3:0] PR_NE  = 4'd1;
	localparam logic [3:0] PR_SLT = 4'd2;
	localparam logic [3:0] PR_SLE = 4'd3;
	localparam logic [3:0] PR_SGT = 4'd4;
	localparam logic [3:0] PR_SGE = 4'd5;
	localparam logic [3:0] PR_ULT = 4'd6;
	localparam logic [3:0] PR_ULE = 4'd7;
	localparam logic [3:0] PR_UGT = 4'd8;
	localparam logic [3:0] PR_UGE = 4'd9;

	typedef struct packed {
		logic [4:0]         func;
		logic [3:0]         predicate;
		logic signed [63:0] operand_a;
		logic signed [63:0] operand_b;
		logic [6:0]         operand_width;
		logic [6:0]         result_width;
	} in_item_t;

	typedef struct packed {
		logic               folded;
		logic signed [63:0] result;
	} out_item_t;

	typedef enum logic [1:0] {K_OTHER, K_MUL, K_DIV, K_REM} kind_t;

	// Work carried down the chain. For a multiply x is the shifted multiplicand,
	// y the remaining multiplier and acc the partial product. For a divide x is
	// the dividend shifting out at the top, y the divisor and acc the remainder.
	typedef struct packed {
		kind_t       kind;
		logic        folded;
		logic [63:0] val;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] acc;
		logic [63:0] q;
		logic        negq;
		logic        negr;
		logic [6:0]  rw;
	} cell_t;

	function automatic logic [63:0] width_mask(input logic [6:0] w);
		logic [63:0] m;
		if (w >= 7'd64) begin
			m = '1;
		end else begin
			m = (64'd1 << w[5:0]) - 64'd1;
		end
		return m;
	endfunction

	function automatic logic [63:0] zview(input logic [63:0] v, input logic [6:0] w);
		return v & width_mask(w);
	endfunction

	function automatic logic [63:0] sview(input logic [63:0] v, input logic [6:0] w);
		logic [63:0] sb;
		logic [63:0] r;
		if (w >= 7'd64 || w == 7'd0) begin
			r = v;
		end else begin
			sb = 64'd1 << (w[5:0] - 6'd1);
			r = (zview(v, w) ^ sb) - sb;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/vwia_decode.sv
`timescale 1ns / 1ps

module vwia_decode #(
	parameter int DATA_WIDTH = vwia_pkg::DATA_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  vwia_pkg::in_item_t in_data,
	output logic              valid_s1,
	output vwia_pkg::cell_t   cell_s1
);
	import vwia_pkg::*;

	localparam logic [6:0] DW7 = 7'(DATA_WIDTH);

	logic [6:0]  ow, rw, swi, swa, swc;
	logic [63:0] a, b;
	logic [63:0] csa, csb, cua, cub;
	logic [63:0] sa, sb, ua, ub;
	logic [5:0]  amt;
	logic        slt, sgt;
	cell_t       c;

	always_comb begin
		a   = in_data.operand_a;
		b   = in_data.operand_b;
		ow  = (in_data.operand_width > DW7) ? DW7 : in_data.operand_width;
		rw  = (in_data.result_width > DW7) ? DW7 : in_data.result_width;
		swi = (ow != 7'd0) ? ow : 7'd32;
		swa = (ow != 7'd0) ? ow : rw;
		swc = swi;
		csa = sview(a, swi);
		csb = sview(b, swi);
		cua = zview(a, swi);
		cub = zview(b, swi);
		sa  = sview(a, swa);
		sb  = sview(b, swa);
		ua  = zview(a, swa);
		ub  = zview(b, swa);
		amt = b[5:0] & 6'(swa - 7'd1);
		slt = $signed(csa) < $signed(csb);
		sgt = $signed(csb) < $signed(csa);

		c        = '0;
		c.kind   = K_OTHER;
		c.rw     = rw;
		c.folded = 1'b1;

		if (in_data.func == FN_ICMP) begin
			c.rw = 7'd64;
			case (in_data.predicate)
				PR_EQ:   c.val = {63'd0, cua == cub};
				PR_NE:   c.val = {63'd0, cua != cub};
				PR_SLT:  c.val = {63'd0, slt};
				PR_SLE:  c.val = {63'd0, !sgt};
				PR_SGT:  c.val = {63'd0, sgt};
				PR_SGE:  c.val = {63'd0, !slt};
				PR_ULT:  c.val = {63'd0, cua < cub};
				PR_ULE:  c.val = {63'd0, cua <= cub};
				PR_UGT:  c.val = {63'd0, cua > cub};
				PR_UGE:  c.val = {63'd0, cua >= cub};
				default: c.folded = 1'b0;
			endcase
		end else if (rw == 7'd0 || in_data.func > FN_SEXT) begin
			c.folded = 1'b0;
		end else begin
			case (in_data.func)
				FN_ADD: c.val = a + b;
				FN_SUB: c.val = a - b;
				FN_MUL: begin
					c.kind = K_MUL;
					c.x    = a;
					c.y    = b;
				end
				FN_SDIV, FN_SREM: begin
					c.kind = (in_data.func == FN_SREM) ? K_REM : K_DIV;
					c.x    = sa[63] ? (64'd0 - sa) : sa;
					c.y    = sb[63] ? (64'd0 - sb) : sb;
					c.negq = sa[63] ^ sb[63];
					c.negr = sa[63];
					if (ub == 64'd0 || (sb == '1 && sa == 64'h8000_0000_0000_0000)) begin
						c.folded = 1'b0;
					end
				end
				FN_UDIV, FN_UREM: begin
					c.kind = (in_data.func == FN_UREM) ? K_REM : K_DIV;
					c.x    = ua;
					c.y    = ub;
					if (ub == 64'd0) begin
						c.folded = 1'b0;
					end
				end
				FN_AND:   c.val = a & b;
				FN_OR:    c.val = a | b;
				FN_XOR:   c.val = a ^ b;
				FN_SHL:   c.val = a << amt;
				FN_LSHR:  c.val = ua >> amt;
				FN_ASHR:  c.val = 64'($signed(sa) >>> amt);
				FN_TRUNC: c.val = a;
				FN_ZEXT:  c.val = zview(a, swc);
				default:  c.val = sview(a, swc);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_s1 <= c;
		end
	end

endmodule

FILE: rtl/core/vwia_cell.sv
`timescale 1ns / 1ps

module vwia_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_i,
	input  vwia_pkg::cell_t cell_i,
	output logic            valid_q,
	output vwia_pkg::cell_t cell_q
);
	import vwia_pkg::*;

	cell_t       n;
	logic [64:0] part;
	logic [64:0] diff;

	always_comb begin
		n    = cell_i;
		part = {cell_i.acc, cell_i.x[63]};
		diff = part - {1'b0, cell_i.y};
		case (cell_i.kind)
			K_MUL: begin
				if (cell_i.y[0]) begin
					n.acc = cell_i.acc + cell_i.x;
				end
				n.x = cell_i.x << 1;
				n.y = cell_i.y >> 1;
			end
			K_DIV, K_REM: begin
				// One restoring step: the remainder stays below the divisor.
				if (!diff[64]) begin
					n.acc = diff[63:0];
					n.q   = {cell_i.q[62:0], 1'b1};
				end else begin
					n.acc = part[63:0];
					n.q   = {cell_i.q[62:0], 1'b0};
				end
				n.x = cell_i.x << 1;
			end
			default: n = cell_i;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= n;
		end
	end

endmodule

FILE: rtl/core/variable_width_integer_alu.sv
`timescale 1ns / 1ps

// Integer ALU with compare over 64-bit operands and variable operand and result
// widths. While the output is not stalled it takes one item per cycle, and it
// answers each with one result item via a decode stage, a row of 64 cells that
// each do one shift-add step of a multiply or one restoring step of a divide,
// and an output register that fixes signs and masks to the result width. All
// other operations ride the same row unchanged. A stalled output holds the
// whole row, so in_ready follows out_ready while a result waits.
module variable_width_integer_alu #(
	parameter int DATA_WIDTH = vwia_pkg::DATA_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  vwia_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output vwia_pkg::out_item_t out_data
);
	import vwia_pkg::*;

	logic      en;
	logic      valid_c [WORD+1];
	cell_t     cell_c  [WORD+1];
	logic      out_valid_q;
	out_item_t out_q;
	out_item_t fin;
	cell_t     last;
	logic [63:0] raw;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	vwia_decode #(.DATA_WIDTH(DATA_WIDTH)) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_data  (in_data),
		.valid_s1 (valid_c[0]),
		.cell_s1  (cell_c[0])
	);

	for (genvar i = 0; i < WORD; i++) begin : g_cell
		vwia_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (valid_c[i]),
			.cell_i  (cell_c[i]),
			.valid_q (valid_c[i+1]),
			.cell_q  (cell_c[i+1])
		);
	end

	always_comb begin
		last = cell_c[WORD];
		case (last.kind)
			K_MUL:   raw = last.acc;
			K_DIV:   raw = last.negq ? (64'd0 - last.q) : last.q;
			K_REM:   raw = last.negr ? (64'd0 - last.acc) : last.acc;
			default: raw = last.val;
		endcase
		fin.folded = last.folded;
		fin.result = last.folded ? (raw & width_mask(last.rw)) : 64'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_c[WORD];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= fin;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.folded |-> out_data.result == 64'd0)
		else $error("refused item carries a nonzero result");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item accepted while the row is stalled");

	a_stall_holds_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(valid_c[WORD]))
		else $error("row moved during a stall");

endmodule
